// ===== sv/round_robin_task_scheduler_defines.svh =====
// ---------------------------------------------------------------------------
// Round-robin task scheduler assertion macros
// Shared macros for the concurrent checks on the scheduler ports.
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH

// Check that is switched off while the synchronous reset is asserted.
`define RRTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define RRTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/rrts_pkg.sv =====
// ---------------------------------------------------------------------------
// Round-robin task scheduler package
// Transaction types, status codes and controller states of the scheduler.
// ---------------------------------------------------------------------------
package rrts_pkg;

    localparam int unsigned TASK_ID_W       = 8;
    localparam int unsigned BURST_W         = 16;
    localparam int unsigned QUANTUM_W       = 8;
    localparam int unsigned TASKS_WAITING_W = 7;

    localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd10;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    localparam logic [1:0] ST_ADDED = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_SLICE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic                 op;
        logic [TASK_ID_W-1:0] task_id;
        logic [BURST_W-1:0]   burst;
    } t_in;

    typedef struct packed {
        logic [1:0]                 status;
        logic [TASK_ID_W-1:0]       slot_task;
        logic [BURST_W-1:0]         slice_length;
        logic                       task_done;
        logic [TASKS_WAITING_W-1:0] tasks_waiting;
    } t_out;

    typedef struct packed {
        logic [TASK_ID_W-1:0] id;
        logic [BURST_W-1:0]   rem;
    } t_entry;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

// ===== sv/rrts_ram.sv =====
// ---------------------------------------------------------------------------
// Round-robin task scheduler RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module rrts_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/round_robin_task_scheduler.sv =====
// ---------------------------------------------------------------------------
// Round-robin task scheduler
// Circular task queue in RAM that hands out time slices of at most one
// quantum, bar the last task left, and requeues unfinished tasks at the tail.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_stall  i_in_data (t_in)
// out       output     o_out_valid / i_out_stall o_out_data (t_out)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (quantum)
//
// Every transaction is accepted in S_IDLE, which starts the registered read
// of the head entry, and finished in S_EXEC, which updates the pointers,
// writes the tail entry back and waits while the output is stalled.
// Reset is synchronous; the queue comes up empty with a quantum of 10 and
// needs no clearing pass. The next transaction is accepted while a result
// is still held by a stalled output.
// ---------------------------------------------------------------------------
module round_robin_task_scheduler
    import rrts_pkg::*;
#(
    parameter int unsigned MAX_TASKS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [QUANTUM_W-1:0] i_cfg_data
);

    localparam int unsigned IDX_W  = $clog2(MAX_TASKS);
    localparam int unsigned CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int unsigned WAIT_W = (CNT_W > TASKS_WAITING_W) ? CNT_W : TASKS_WAITING_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [IDX_W-1:0]   r_tail, n_tail;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [QUANTUM_W-1:0] r_quantum;
    t_in                r_item;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;

    logic               w_in_accept;
    logic               w_out_free;
    logic               w_we;
    t_entry             w_wdata;
    logic [$bits(t_entry)-1:0] w_rdata;
    t_entry             w_rd_entry;
    logic [BURST_W-1:0] w_quantum;
    logic [IDX_W-1:0]   w_head_adv;
    logic [IDX_W-1:0]   w_tail_adv;
    logic [WAIT_W-1:0]  w_wait_ext;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign w_rd_entry = t_entry'(w_rdata);
    assign w_quantum  = {{(BURST_W - QUANTUM_W){1'b0}},
                         (r_quantum == '0) ? QUANTUM_W'(1) : r_quantum};
    assign w_head_adv = (r_head == LAST_IDX) ? '0 : r_head + IDX_W'(1);
    assign w_tail_adv = (r_tail == LAST_IDX) ? '0 : r_tail + IDX_W'(1);

    rrts_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_TASKS)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (w_wdata),
        .i_re    (w_in_accept),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_we        = 1'b0;
        w_wdata     = '0;
        w_wait_ext  = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    if (r_item.op == OP_ADD) begin
                        if (r_count == FULL_CNT) begin
                            n_out.status = ST_FULL;
                        end else begin
                            w_we         = 1'b1;
                            w_wdata.id   = r_item.task_id;
                            w_wdata.rem  = r_item.burst;
                            n_tail       = w_tail_adv;
                            n_count      = r_count + CNT_W'(1);
                            n_out.status = ST_ADDED;
                        end
                    end else if (r_count == '0) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        n_out.status    = ST_SLICE;
                        n_out.slot_task = w_rd_entry.id;
                        n_head          = w_head_adv;
                        if ((r_count == CNT_W'(1)) || (w_rd_entry.rem <= w_quantum)) begin
                            n_out.slice_length = w_rd_entry.rem;
                            n_out.task_done    = 1'b1;
                            n_count            = r_count - CNT_W'(1);
                        end else begin
                            w_we               = 1'b1;
                            w_wdata.id         = w_rd_entry.id;
                            w_wdata.rem        = w_rd_entry.rem - w_quantum;
                            n_tail             = w_tail_adv;
                            n_out.slice_length = w_quantum;
                        end
                    end
                    w_wait_ext          = WAIT_W'(n_count);
                    n_out.tasks_waiting = w_wait_ext[TASKS_WAITING_W-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_quantum   <= QUANTUM_RESET;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_quantum <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_item <= i_in_data;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/rrts_checker.sv =====
// ---------------------------------------------------------------------------
// Round-robin task scheduler checker
// Port-level assertions on the scheduler, attached by a bind statement.
// ---------------------------------------------------------------------------
`include "round_robin_task_scheduler_defines.svh"

module rrts_checker
    import rrts_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out                 o_out_data
);

    // A result held by a stalled output stays in place.
    `RRTS_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data), "stalled result changed")

    // The scheduler works on one transaction at a time.
    `RRTS_ASSERT(a_one_at_a_time, i_in_valid && !o_in_stall |=> o_in_stall, "transaction accepted in back-to-back cycles")

    // Add results carry no slice information.
    `RRTS_ASSERT(a_add_clean, o_out_valid && (o_out_data.status == ST_ADDED || o_out_data.status == ST_FULL) |-> o_out_data.slot_task == '0 && o_out_data.slice_length == '0 && !o_out_data.task_done, "add result has slice fields set")

    // A slice that requeues its task runs exactly one nonzero quantum.
    `RRTS_ASSERT(a_requeue_len, o_out_valid && o_out_data.status == ST_SLICE && !o_out_data.task_done |-> o_out_data.slice_length != '0 && o_out_data.slice_length[15:8] == '0 && o_out_data.tasks_waiting != '0, "requeued slice has bad length or empty queue")

    // An empty queue reports nothing waiting.
    `RRTS_ASSERT(a_empty_clean, o_out_valid && o_out_data.status == ST_EMPTY |-> o_out_data.tasks_waiting == '0 && o_out_data.slot_task == '0, "empty result has nonzero fields")

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (.*);

// ===== bench/round_robin_task_scheduler_tb.sv =====
// ---------------------------------------------------------------------------
// Round-robin task scheduler testbench
// Drives add and next transactions through the scheduler with random idle
// cycles on both channels, predicts every result with a behavioral copy of
// the task ring, and checks each output transaction field by field. The
// quantum is rewritten between phases, including zero, one and the maximum.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module round_robin_task_scheduler_tb;
    import rrts_pkg::*;

    localparam int unsigned TASK_SLOTS = 64;
    localparam int unsigned LONG_HOLD  = 200;
    localparam int unsigned STUCK_LIMIT = 2000;
    localparam int unsigned PHASES     = 6;
    localparam int unsigned PHASE_OPS  = 150;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in                  i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out                 o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [QUANTUM_W-1:0] i_cfg_data  = '0;

    t_in  task_ops_q[$];
    t_out outcome_q[$];

    t_entry               task_ring[TASK_SLOTS];
    int unsigned          ring_head = 0;
    int unsigned          ring_tail = 0;
    int unsigned          ring_fill = 0;
    logic [QUANTUM_W-1:0] quantum_q = QUANTUM_RESET;

    t_in         cur_task_op = '0;
    bit          in_busy     = 1'b0;
    bit          hold_sender = 1'b0;
    bit          quiet_tx    = 1'b0;
    bit          quiet_rx    = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned send_gap    = 0;
    int unsigned stall_wait  = 0;
    int unsigned hold_left   = 0;
    int unsigned stuck_count = 0;
    int          err_count   = 0;
    t_out        want;

    round_robin_task_scheduler #(
        .MAX_TASKS(TASK_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned pick_wait(input bit calm);
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic t_out schedule_item(input t_in item);
        t_out               res;
        t_entry             ent;
        logic [BURST_W-1:0] slice;
        res = '0;
        if (item.op == OP_ADD) begin
            if (ring_fill >= TASK_SLOTS) begin
                res.status = ST_FULL;
            end else begin
                ent.id = item.task_id;
                ent.rem = item.burst;
                task_ring[ring_tail] = ent;
                ring_tail = (ring_tail + 1) % TASK_SLOTS;
                ring_fill++;
                res.status = ST_ADDED;
            end
        end else if (ring_fill == 0) begin
            res.status = ST_EMPTY;
        end else begin
            ent = task_ring[ring_head];
            ring_head = (ring_head + 1) % TASK_SLOTS;
            ring_fill--;
            slice = (quantum_q == '0) ? BURST_W'(1) : BURST_W'(quantum_q);
            res.status = ST_SLICE;
            res.slot_task = ent.id;
            if (ring_fill == 0 || ent.rem <= slice) begin
                res.slice_length = ent.rem;
                res.task_done = 1'b1;
            end else begin
                ent.rem = ent.rem - slice;
                task_ring[ring_tail] = ent;
                ring_tail = (ring_tail + 1) % TASK_SLOTS;
                ring_fill++;
                res.slice_length = slice;
            end
        end
        res.tasks_waiting = TASKS_WAITING_W'(ring_fill);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_busy = 1'b0;
            i_in_valid <= 1'b0;
        end else begin
            if (in_busy && !o_in_stall) begin
                outcome_q.push_back(schedule_item(cur_task_op));
                in_busy = 1'b0;
                send_gap = pick_wait(quiet_tx);
            end
            if (!in_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (task_ops_q.size() != 0 && !hold_sender) begin
                    cur_task_op = task_ops_q.pop_front();
                    in_busy = 1'b1;
                end
            end
            i_in_valid <= in_busy;
            i_in_data <= cur_task_op;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (outcome_q.size() == 0) begin
                    $error("unexpected result transaction %h", o_out_data);
                    err_count++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("status", want.status, o_out_data.status);
                    check_field("slot_task", want.slot_task, o_out_data.slot_task);
                    check_field("slice_length", want.slice_length,
                                o_out_data.slice_length);
                    check_field("task_done", want.task_done, o_out_data.task_done);
                    check_field("tasks_waiting", want.tasks_waiting,
                                o_out_data.tasks_waiting);
                end
                stall_wait = pick_wait(quiet_rx);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_wait > 0) begin
                stall_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stuck_count <= 0;
            end else if (stuck_count >= STUCK_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                stuck_count <= stuck_count + 1;
            end
        end
    end

    task automatic queue_op(input logic op, input logic [TASK_ID_W-1:0] id,
                            input logic [BURST_W-1:0] burst);
        t_in item;
        item.op = op;
        item.task_id = id;
        item.burst = burst;
        task_ops_q.push_back(item);
    endtask

    task automatic queue_random_ops(input int unsigned count, input int unsigned add_pct);
        int unsigned        pick;
        logic [BURST_W-1:0] burst;
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                burst = '0;
            end else if (pick == 1) begin
                burst = '1;
            end else if (pick < 7) begin
                burst = BURST_W'($urandom_range(0, 600));
            end else begin
                burst = BURST_W'($urandom_range(0, 65535));
            end
            queue_op(($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_NEXT,
                     TASK_ID_W'($urandom_range(0, 255)), burst);
        end
    endtask

    task automatic wait_drained;
        while (task_ops_q.size() != 0 || in_busy || outcome_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_quantum(input logic [QUANTUM_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        quantum_q = value;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [QUANTUM_W-1:0] phase_quantum[PHASES];
        int unsigned          phase_add_pct[PHASES];

        phase_quantum = '{8'd1, 8'd255, 8'd0, QUANTUM_W'($urandom_range(2, 254)),
                          QUANTUM_W'($urandom_range(0, 255)), QUANTUM_RESET};
        phase_add_pct = '{75, 55, 60, 45, 50, 35};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_op(OP_NEXT, 8'h00, 16'h0000);
        queue_op(OP_ADD, 8'h00, 16'h0000);
        queue_op(OP_ADD, 8'hFF, 16'hFFFF);
        queue_op(OP_ADD, 8'hA5, 16'd10);
        queue_op(OP_ADD, 8'h5A, 16'd11);
        queue_op(OP_ADD, 8'h3C, 16'd9);
        repeat (8) queue_op(OP_NEXT, 8'hFF, 16'hFFFF);
        queue_op(OP_ADD, 8'h81, 16'd1);
        queue_op(OP_NEXT, 8'h00, 16'h0000);
        queue_op(OP_NEXT, 8'h00, 16'h0000);
        wait_drained();

        for (int unsigned ph = 0; ph < PHASES; ph++) begin
            write_quantum(phase_quantum[ph]);
            quiet_tx = (ph == 3);
            quiet_rx = (ph == 3);
            queue_random_ops(PHASE_OPS, phase_add_pct[ph]);
            if (ph == 0) begin
                repeat (40) @(posedge i_clk);
                hold_request = 1'b1;
            end
            if (ph == 4) begin
                repeat (60) @(posedge i_clk);
                hold_sender = 1'b1;
                while (in_busy || outcome_q.size() != 0) @(posedge i_clk);
                repeat (3) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (err_count == 0 && outcome_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
